### rtl/rsakd_pkg.sv
// ----------------------------------------------------------------------------
// rsakd_pkg
// Shared types and constants for the private key derivation core: word
// widths, controller states, datapath operations and the status bundle.
// ----------------------------------------------------------------------------
package rsakd_pkg;

  localparam int WORD_W = 32;
  // signed coefficient width: magnitudes stay below twice the totient
  localparam int T_W    = WORD_W + 2;
  // shift count, holds 0..WORD_W
  localparam int K_W    = $clog2(WORD_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_PHI,
    ST_CHECK,
    ST_RED_UP,
    ST_RED_DOWN,
    ST_RED_END,
    ST_EUC_TEST,
    ST_EUC_UP,
    ST_EUC_DOWN,
    ST_EUC_END,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_N,
    OP_MUL_PHI,
    OP_RED_INIT,
    OP_EUC_INIT,
    OP_UP,
    OP_DOWN,
    OP_RED_DONE,
    OP_EUC_DONE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic phi_small;  // totient is zero or one
    logic up_ok;      // doubled divisor still fits under the remainder
    logic k_zero;     // divisor back at its original alignment
    logic r1_zero;    // euclid remainder reached zero
  } status_t;

endpackage

### rtl/rsakd_ctrl.sv
// ----------------------------------------------------------------------------
// rsakd_ctrl
// Controller: sequences the two multiplies, the reduction of e modulo phi
// and the shift-subtract steps of the extended euclid loop.
// ----------------------------------------------------------------------------
module rsakd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rsakd_pkg::status_t status,
  output rsakd_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);

  rsakd_pkg::state_t state;
  rsakd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsakd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rsakd_pkg::ST_IDLE: begin
        if (start) state_next = rsakd_pkg::ST_MUL_N;
      end
      rsakd_pkg::ST_MUL_N:   state_next = rsakd_pkg::ST_MUL_PHI;
      rsakd_pkg::ST_MUL_PHI: state_next = rsakd_pkg::ST_CHECK;
      rsakd_pkg::ST_CHECK: begin
        state_next = status.phi_small ? rsakd_pkg::ST_DONE : rsakd_pkg::ST_RED_UP;
      end
      rsakd_pkg::ST_RED_UP: begin
        if (!status.up_ok) state_next = rsakd_pkg::ST_RED_DOWN;
      end
      rsakd_pkg::ST_RED_DOWN: begin
        if (status.k_zero) state_next = rsakd_pkg::ST_RED_END;
      end
      rsakd_pkg::ST_RED_END: state_next = rsakd_pkg::ST_EUC_TEST;
      rsakd_pkg::ST_EUC_TEST: begin
        state_next = status.r1_zero ? rsakd_pkg::ST_DONE : rsakd_pkg::ST_EUC_UP;
      end
      rsakd_pkg::ST_EUC_UP: begin
        if (!status.up_ok) state_next = rsakd_pkg::ST_EUC_DOWN;
      end
      rsakd_pkg::ST_EUC_DOWN: begin
        if (status.k_zero) state_next = rsakd_pkg::ST_EUC_END;
      end
      rsakd_pkg::ST_EUC_END: state_next = rsakd_pkg::ST_EUC_TEST;
      rsakd_pkg::ST_DONE:    state_next = rsakd_pkg::ST_IDLE;
      default:               state_next = rsakd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = rsakd_pkg::OP_NONE;
    busy   = 1'b1;
    done   = 1'b0;
    unique case (state)
      rsakd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = rsakd_pkg::OP_LOAD;
      end
      rsakd_pkg::ST_MUL_N:   cmd.op = rsakd_pkg::OP_MUL_N;
      rsakd_pkg::ST_MUL_PHI: cmd.op = rsakd_pkg::OP_MUL_PHI;
      rsakd_pkg::ST_CHECK: begin
        cmd.op = status.phi_small ? rsakd_pkg::OP_FINISH : rsakd_pkg::OP_RED_INIT;
      end
      rsakd_pkg::ST_RED_UP: begin
        if (status.up_ok) cmd.op = rsakd_pkg::OP_UP;
      end
      rsakd_pkg::ST_RED_DOWN: cmd.op = rsakd_pkg::OP_DOWN;
      rsakd_pkg::ST_RED_END:  cmd.op = rsakd_pkg::OP_RED_DONE;
      rsakd_pkg::ST_EUC_TEST: begin
        cmd.op = status.r1_zero ? rsakd_pkg::OP_FINISH : rsakd_pkg::OP_EUC_INIT;
      end
      rsakd_pkg::ST_EUC_UP: begin
        if (status.up_ok) cmd.op = rsakd_pkg::OP_UP;
      end
      rsakd_pkg::ST_EUC_DOWN: cmd.op = rsakd_pkg::OP_DOWN;
      rsakd_pkg::ST_EUC_END:  cmd.op = rsakd_pkg::OP_EUC_DONE;
      rsakd_pkg::ST_DONE:     done = 1'b1;
      default:                cmd.op = rsakd_pkg::OP_NONE;
    endcase
  end

endmodule

### rtl/rsakd_dp.sv
// ----------------------------------------------------------------------------
// rsakd_dp
// Datapath: one shared 32x32 multiplier for n and phi, and a shift-subtract
// divider that also updates the euclid coefficient as it subtracts.
// ----------------------------------------------------------------------------
module rsakd_dp #(
  parameter int PRIME_WIDTH = 16
) (
  input  logic                          clk,
  input  rsakd_pkg::cmd_t                cmd,
  input  logic [PRIME_WIDTH-1:0]        prime_p,
  input  logic [PRIME_WIDTH-1:0]        prime_q,
  input  logic [rsakd_pkg::WORD_W-1:0]  public_exponent,
  output rsakd_pkg::status_t             status,
  output logic [rsakd_pkg::WORD_W-1:0]  modulus,
  output logic [rsakd_pkg::WORD_W-1:0]  totient,
  output logic [rsakd_pkg::WORD_W-1:0]  private_exponent,
  output logic                          no_inverse
);

  logic [PRIME_WIDTH-1:0]              p_reg;
  logic [PRIME_WIDTH-1:0]              q_reg;
  logic [rsakd_pkg::WORD_W-1:0]        e_reg;
  logic [rsakd_pkg::WORD_W-1:0]        r0;
  logic [rsakd_pkg::WORD_W-1:0]        r1;
  logic signed [rsakd_pkg::T_W-1:0]    t0;
  logic signed [rsakd_pkg::T_W-1:0]    t1;
  logic [rsakd_pkg::WORD_W-1:0]        rem;
  logic [rsakd_pkg::WORD_W-1:0]        ds;
  logic signed [rsakd_pkg::T_W-1:0]    ts;
  logic signed [rsakd_pkg::T_W-1:0]    tacc;
  logic [rsakd_pkg::K_W-1:0]           k;

  logic [rsakd_pkg::WORD_W-1:0]        p_ext;
  logic [rsakd_pkg::WORD_W-1:0]        q_ext;
  logic [rsakd_pkg::WORD_W-1:0]        mul_a;
  logic [rsakd_pkg::WORD_W-1:0]        mul_b;
  logic [rsakd_pkg::WORD_W-1:0]        prod;
  logic                                sub_ok;
  logic                                fail;
  logic signed [rsakd_pkg::T_W-1:0]    d_fix;

  assign p_ext = rsakd_pkg::WORD_W'(p_reg);
  assign q_ext = rsakd_pkg::WORD_W'(q_reg);

  // only the low word of the product is kept
  always_comb begin
    if (cmd.op == rsakd_pkg::OP_MUL_PHI) begin
      mul_a = p_ext - rsakd_pkg::WORD_W'(1);
      mul_b = q_ext - rsakd_pkg::WORD_W'(1);
    end else begin
      mul_a = p_ext;
      mul_b = q_ext;
    end
  end

  assign prod   = mul_a * mul_b;
  assign sub_ok = (ds <= rem);

  assign status.phi_small = (totient <= rsakd_pkg::WORD_W'(1));
  assign status.up_ok     = ({ds, 1'b0} <= {1'b0, rem});
  assign status.k_zero    = (k == '0);
  assign status.r1_zero   = (r1 == '0);

  assign fail  = status.phi_small || (r0 != rsakd_pkg::WORD_W'(1));
  assign d_fix = t0[rsakd_pkg::T_W-1] ? (t0 + $signed({2'b00, totient})) : t0;

  always_ff @(posedge clk) begin
    case (cmd.op)
      rsakd_pkg::OP_LOAD: begin
        p_reg <= prime_p;
        q_reg <= prime_q;
        e_reg <= public_exponent;
      end
      rsakd_pkg::OP_MUL_N: begin
        modulus <= prod;
      end
      rsakd_pkg::OP_MUL_PHI: begin
        totient <= (p_reg == '0 || q_reg == '0) ? '0 : prod;
      end
      rsakd_pkg::OP_RED_INIT: begin
        rem  <= e_reg;
        ds   <= totient;
        ts   <= '0;
        tacc <= '0;
        k    <= '0;
      end
      rsakd_pkg::OP_EUC_INIT: begin
        rem  <= r0;
        ds   <= r1;
        ts   <= t1;
        tacc <= t0;
        k    <= '0;
      end
      rsakd_pkg::OP_UP: begin
        ds <= {ds[rsakd_pkg::WORD_W-2:0], 1'b0};
        ts <= ts <<< 1;
        k  <= k + rsakd_pkg::K_W'(1);
      end
      rsakd_pkg::OP_DOWN: begin
        // quotient bit k: subtract divisor and the matching coefficient
        if (sub_ok) begin
          rem  <= rem - ds;
          tacc <= tacc - ts;
        end
        if (!status.k_zero) begin
          ds <= ds >> 1;
          ts <= ts >>> 1;
          k  <= k - rsakd_pkg::K_W'(1);
        end
      end
      rsakd_pkg::OP_RED_DONE: begin
        r0 <= totient;
        r1 <= rem;
        t0 <= '0;
        t1 <= rsakd_pkg::T_W'(1);
      end
      rsakd_pkg::OP_EUC_DONE: begin
        r0 <= r1;
        r1 <= rem;
        t0 <= t1;
        t1 <= tacc;
      end
      rsakd_pkg::OP_FINISH: begin
        no_inverse       <= fail;
        private_exponent <= fail ? '0 : d_fix[rsakd_pkg::WORD_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/rsa_private_key_derivation_core.sv
// ----------------------------------------------------------------------------
// rsa_private_key_derivation_core
// Derives n = p*q, phi = (p-1)*(q-1) and d = e^-1 mod phi by extended euclid.
// ----------------------------------------------------------------------------
// sequence: the two multiplies, then a check that ends the run when phi is 0
//   or 1; else e mod phi and then the euclid steps, each division run by the
//   shift-subtract unit, which doubles the divisor up and then takes one
//   quotient bit per cycle on the way down
// throughput: one word at a time, busy stays high through the done strobe
// reset: synchronous, returns the controller to idle; results valid with done
module rsa_private_key_derivation_core #(
  parameter int PRIME_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [PRIME_WIDTH-1:0] prime_p,
  input  logic [PRIME_WIDTH-1:0] prime_q,
  input  logic [31:0]            public_exponent,
  output logic                   done,
  output logic [31:0]            modulus,
  output logic [31:0]            totient,
  output logic [31:0]            private_exponent,
  output logic                   no_inverse
);

  rsakd_pkg::cmd_t    cmd;
  rsakd_pkg::status_t status;

  rsakd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rsakd_dp #(
    .PRIME_WIDTH (PRIME_WIDTH)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .prime_p          (prime_p),
    .prime_q          (prime_q),
    .public_exponent  (public_exponent),
    .status           (status),
    .modulus          (modulus),
    .totient          (totient),
    .private_exponent (private_exponent),
    .no_inverse       (no_inverse)
  );

endmodule

### rtl/rsakd_checker.sv
// ----------------------------------------------------------------------------
// rsakd_checker
// Port-level checks on the start/busy/done sequence and the result word.
// ----------------------------------------------------------------------------
module rsakd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] totient,
  input logic [31:0] private_exponent,
  input logic        no_inverse
);

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_done_in_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done strobe outside a busy window");

  a_done_release : assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("core not released after done");

  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    done && no_inverse |-> private_exponent == 32'd0)
    else $error("nonzero d with no inverse");

  a_d_range : assert property (@(posedge clk) disable iff (rst)
    done && !no_inverse |-> private_exponent != 32'd0 && private_exponent < totient)
    else $error("d out of range 1..phi-1");

endmodule

bind rsa_private_key_derivation_core rsakd_checker u_rsakd_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .totient          (totient),
  .private_exponent (private_exponent),
  .no_inverse       (no_inverse)
);
